// ===== rtl/dmap_pkg.sv =====
// Shared types and constants for the depth-to-color pixel mapper.
// Used by every module in rtl/; depends on nothing else.
package dmap_pkg;

  // Color image bounds for a valid mapped point.
  localparam int COLOR_WIDTH  = 640;
  localparam int COLOR_HEIGHT = 480;

  // Quotient bits of the depth divide; one cell per bit.
  localparam int DIV_BITS = 40;

  // Cycles from an accepted start to its done strobe.
  localparam int LATENCY = DIV_BITS + 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_COL   = 3'd0;
  localparam logic [2:0] REG_X_ROW   = 3'd1;
  localparam logic [2:0] REG_X_CONST = 3'd2;
  localparam logic [2:0] REG_Y_COL   = 3'd3;
  localparam logic [2:0] REG_Y_ROW   = 3'd4;
  localparam logic [2:0] REG_Y_CONST = 3'd5;
  localparam logic [2:0] REG_X_SHIFT = 3'd6;
  localparam logic [2:0] REG_Y_SHIFT = 3'd7;

  // Input word.
  typedef struct packed {
    logic [9:0]  depth_col;
    logic [9:0]  depth_row;
    logic [15:0] depth_mm;
  } dmap_in_t;

  // Result word.
  typedef struct packed {
    logic [9:0]  color_x;
    logic [9:0]  color_y;
    logic [15:0] depth_pass;
    logic        map_valid;
  } dmap_out_t;

  // Folded register set, as seen by the front stage.
  typedef struct packed {
    logic signed [31:0] x_col;
    logic signed [31:0] x_row;
    logic signed [31:0] x_const;
    logic signed [31:0] y_col;
    logic signed [31:0] y_row;
    logic signed [31:0] y_const;
    logic signed [39:0] x_shift;
    logic signed [39:0] y_shift;
  } dmap_cfg_t;

  // One pixel as it moves down the divide chain. The w fields hold the
  // remaining dividend bits at the top and the quotient bits at the bottom.
  typedef struct packed {
    logic               vld;
    logic [15:0]        depth;
    logic signed [43:0] sx;
    logic signed [43:0] sy;
    logic [39:0]        wx;
    logic [39:0]        wy;
    logic [15:0]        rx;
    logic [15:0]        ry;
    logic               nx;
    logic               ny;
  } dmap_lane_t;

endpackage

// ===== rtl/dmap_front.sv =====
// Front stage: evaluates the affine part of both axes and prepares the
// translation magnitudes for the divide chain. Depends on dmap_pkg.
module dmap_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dmap_pkg::dmap_in_t    pixel_in,
  input  dmap_pkg::dmap_cfg_t   cfg,
  output dmap_pkg::dmap_lane_t  lane_out
);
  import dmap_pkg::*;

  logic signed [10:0] col_ext;
  logic signed [10:0] row_ext;
  logic signed [43:0] sx_next;
  logic signed [43:0] sy_next;
  logic [39:0]        mx_next;
  logic [39:0]        my_next;

  // Affine sums in Q28.16 from Q16.16 coefficients; each product fits comfortably in 44 bits.
  always_comb begin
    col_ext = signed'({1'b0, pixel_in.depth_col});
    row_ext = signed'({1'b0, pixel_in.depth_row});
    sx_next = 44'(44'(cfg.x_col) * col_ext) + 44'(44'(cfg.x_row) * row_ext)
              + 44'(cfg.x_const);
    sy_next = 44'(44'(cfg.y_col) * col_ext) + 44'(44'(cfg.y_row) * row_ext)
              + 44'(cfg.y_const);
    mx_next = cfg.x_shift[39] ? 40'(-cfg.x_shift) : cfg.x_shift;
    my_next = cfg.y_shift[39] ? 40'(-cfg.y_shift) : cfg.y_shift;
  end

  // Launch register for the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else begin
      lane_out.vld <= start;
    end
    lane_out.depth <= pixel_in.depth_mm;
    lane_out.sx    <= sx_next;
    lane_out.sy    <= sy_next;
    lane_out.wx    <= mx_next;
    lane_out.wy    <= my_next;
    lane_out.rx    <= '0;
    lane_out.ry    <= '0;
    lane_out.nx    <= cfg.x_shift[39];
    lane_out.ny    <= cfg.y_shift[39];
  end

endmodule

// ===== rtl/dmap_cell.sv =====
// One cell of the divide chain: produces one quotient bit for each axis.
// Depends on dmap_pkg.
module dmap_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  dmap_pkg::dmap_lane_t  lane_in,
  output dmap_pkg::dmap_lane_t  lane_out
);
  import dmap_pkg::*;

  logic [16:0] tx;
  logic [16:0] ty;
  logic        gx;
  logic        gy;
  logic [16:0] dx;
  logic [16:0] dy;

  // Restoring step: bring in the next dividend bit and try the depth.
  always_comb begin
    tx = {lane_in.rx, lane_in.wx[39]};
    ty = {lane_in.ry, lane_in.wy[39]};
    gx = tx >= {1'b0, lane_in.depth};
    gy = ty >= {1'b0, lane_in.depth};
    dx = tx - {1'b0, lane_in.depth};
    dy = ty - {1'b0, lane_in.depth};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else begin
      lane_out.vld <= lane_in.vld;
    end
    lane_out.depth <= lane_in.depth;
    lane_out.sx    <= lane_in.sx;
    lane_out.sy    <= lane_in.sy;
    lane_out.wx    <= {lane_in.wx[38:0], gx};
    lane_out.wy    <= {lane_in.wy[38:0], gy};
    lane_out.rx    <= gx ? dx[15:0] : tx[15:0];
    lane_out.ry    <= gy ? dy[15:0] : ty[15:0];
    lane_out.nx    <= lane_in.nx;
    lane_out.ny    <= lane_in.ny;
  end

endmodule

// ===== rtl/dmap_back.sv =====
// Back end: floor correction of the quotients, rounding, bounds check and
// the result register. Depends on dmap_pkg.
module dmap_back (
  input  logic                  clk,
  input  logic                  rst,
  input  dmap_pkg::dmap_lane_t  lane_in,
  output logic                  done,
  output dmap_pkg::dmap_out_t   pixel_out
);
  import dmap_pkg::*;

  logic               a_vld;
  logic [15:0]        a_depth;
  logic signed [44:0] a_bx;
  logic signed [44:0] a_by;
  logic signed [41:0] a_qx;
  logic signed [41:0] a_qy;

  logic signed [41:0] qx_next;
  logic signed [41:0] qy_next;
  logic signed [45:0] ux;
  logic signed [45:0] uy;
  logic signed [29:0] cx;
  logic signed [29:0] cy;
  logic               ok;

  // Turn the magnitude quotient into a floor quotient of the signed term.
  always_comb begin
    qx_next = signed'({2'b00, lane_in.wx});
    qy_next = signed'({2'b00, lane_in.wy});
    if (lane_in.nx) begin
      qx_next = -qx_next - 42'(lane_in.rx != 16'd0);
    end
    if (lane_in.ny) begin
      qy_next = -qy_next - 42'(lane_in.ry != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= lane_in.vld;
    end
    a_depth <= lane_in.depth;
    a_bx    <= 45'(lane_in.sx) + 45'sd32768;
    a_by    <= 45'(lane_in.sy) + 45'sd32768;
    a_qx    <= qx_next;
    a_qy    <= qy_next;
  end

  // Add the depth term and drop the fraction; the half was added above.
  always_comb begin
    ux = 46'(a_bx) + 46'(a_qx);
    uy = 46'(a_by) + 46'(a_qy);
    cx = ux[45:16];
    cy = uy[45:16];
    ok = (a_depth != 16'd0) && (cx > 30'sd0) && (cy > 30'sd0)
         && (cx < 30'(COLOR_WIDTH)) && (cy < 30'(COLOR_HEIGHT));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_vld;
    end
    pixel_out.color_x    <= ok ? cx[9:0] : 10'd0;
    pixel_out.color_y    <= ok ? cy[9:0] : 10'd0;
    pixel_out.depth_pass <= a_depth;
    pixel_out.map_valid  <= ok;
  end

endmodule

// ===== rtl/depth_to_color_pixel_mapper_unit.sv =====
// Top level of the depth-to-color pixel mapper: register file, front stage,
// divide chain and back end. Depends on dmap_pkg, dmap_front, dmap_cell, dmap_back.
//
// The unit takes one depth word on every clock (busy is always low) and
// returns its mapped color word on done after one front stage, a chain of
// 40 divide cells that each produce one quotient bit of the translation term
// over depth, and two back-end stages. Many words
// are in flight at once and results leave in input order; the receiver
// cannot stall, so it must take each done word in its cycle. Registers are
// written through cfg_we, cfg_index and cfg_data and must only change while
// no word is in flight.
module depth_to_color_pixel_mapper_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dmap_pkg::dmap_in_t  pixel_in,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [39:0]         cfg_data,
  output logic                done,
  output dmap_pkg::dmap_out_t pixel_out
);
  import dmap_pkg::*;

  dmap_cfg_t  cfg;
  dmap_lane_t lane [0:DIV_BITS];

  assign busy = 1'b0;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_col   <= 32'sd65536;
      cfg.x_row   <= '0;
      cfg.x_const <= '0;
      cfg.y_col   <= '0;
      cfg.y_row   <= 32'sd65536;
      cfg.y_const <= '0;
      cfg.x_shift <= '0;
      cfg.y_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_COL:   cfg.x_col   <= cfg_data[31:0];
        REG_X_ROW:   cfg.x_row   <= cfg_data[31:0];
        REG_X_CONST: cfg.x_const <= cfg_data[31:0];
        REG_Y_COL:   cfg.y_col   <= cfg_data[31:0];
        REG_Y_ROW:   cfg.y_row   <= cfg_data[31:0];
        REG_Y_CONST: cfg.y_const <= cfg_data[31:0];
        REG_X_SHIFT: cfg.x_shift <= cfg_data;
        REG_Y_SHIFT: cfg.y_shift <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dmap_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .pixel_in (pixel_in),
    .cfg      (cfg),
    .lane_out (lane[0])
  );

  // Divide chain, one quotient bit per cell.
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
    dmap_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (lane[k]),
      .lane_out (lane[k+1])
    );
  end

  dmap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .lane_in   (lane[DIV_BITS]),
    .done      (done),
    .pixel_out (pixel_out)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done) else $error("accepted word did not come out");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY)) else $error("result without a word");
  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    done && !pixel_out.map_valid |-> pixel_out.color_x == 10'd0 &&
    pixel_out.color_y == 10'd0) else $error("invalid result not zeroed");
  a_depth_ok: assert property (@(posedge clk) disable iff (rst)
    done && pixel_out.map_valid |-> pixel_out.depth_pass != 16'd0)
    else $error("valid result with zero depth");
`endif

endmodule
